[hdl/pdbfd_pkg.sv]
`default_nettype none

package pdbfd_pkg;

  // Default geometry
  localparam int MAX_SLOTS_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int LOW_FRAC_W = 16;
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int AVG_W      = 16;
  localparam int WORD_W     = 32;
  localparam int SLOT_CNT_W = 6;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_FRAC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FRAC = 1'b1;

  // Configuration reset values
  localparam logic [LOW_FRAC_W-1:0] LOW_FRAC_RESET  = 16'd30583;
  localparam logic [FRAC_W-1:0]     HIGH_FRAC_RESET = 17'd56798;

  // Shared unit operation
  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_t;

endpackage

`default_nettype wire

[hdl/pdbfd_ram.sv]
`default_nettype none

module pdbfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/pdbfd_addsub.sv]
`default_nettype none

module pdbfd_addsub #(
  parameter int W = 38
) (
  input  pdbfd_pkg::op_t op,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   res,
  output logic           borrow
);

  import pdbfd_pkg::*;

  logic [W:0] full;

  // Borrow is the top bit of a subtract; it means a < b.
  always_comb begin
    unique case (op)
      OP_ADD:  full = {1'b0, a} + {1'b0, b};
      OP_SUB:  full = {1'b0, a} - {1'b0, b};
      default: full = '0;
    endcase
  end

  assign res    = full[W-1:0];
  assign borrow = (op == OP_SUB) && full[W];

endmodule

`default_nettype wire

[hdl/pwm_duty_bit_frame_decoder.sv]
// A slot word is accepted whenever start is high and busy is low.
// A word marked last_slot with n kept slots (n > 1) keeps busy high until the result strobe,
// which rises in the same cycle that busy falls. Let D = COUNT_WIDTH + clog2(MAX_SLOTS) + 1.
// The time is set by the one shared add/subtract unit: three D-step divisions, two 17-step
// multiplies and two compares per slot. A one-slot frame answers in the cycle after its word.
// Reset (rst_n low, synchronous) clears the frame and loads the default fractions; no clearing pass.
`default_nettype none

module pwm_duty_bit_frame_decoder #(
  parameter int MAX_SLOTS   = pdbfd_pkg::MAX_SLOTS_DEF,
  parameter int COUNT_WIDTH = pdbfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [COUNT_WIDTH-1:0]           in_period_count,
  input  logic [COUNT_WIDTH-1:0]           in_high_count,
  input  logic                             in_last_slot,
  output logic                             out_valid,
  output logic [pdbfd_pkg::WORD_W-1:0]     out_response_word,
  output logic [pdbfd_pkg::AVG_W-1:0]      out_average_period,
  output logic [pdbfd_pkg::SLOT_CNT_W-1:0] out_slot_count,
  output logic                             out_overflow,
  input  logic                             cfg_we,
  input  logic [pdbfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdbfd_pkg::CFG_W-1:0]      cfg_data
);

  import pdbfd_pkg::*;

  localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W   = $clog2(MAX_SLOTS);
  localparam int SUM_W    = COUNT_WIDTH + $clog2(MAX_SLOTS);
  localparam int D_W      = SUM_W + 1;
  localparam int ACC_W    = SUM_W + FRAC_W;
  localparam int ITER_MAX = (D_W > FRAC_W) ? D_W : FRAC_W;
  localparam int IT_W     = $clog2(ITER_MAX + 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_AVG_DIV = 9'b000000010,
    ST_LO_MUL  = 9'b000000100,
    ST_LO_DIV  = 9'b000001000,
    ST_HI_MUL  = 9'b000010000,
    ST_HI_DIV  = 9'b000100000,
    ST_CL_READ = 9'b001000000,
    ST_CL_LO   = 9'b010000000,
    ST_CL_HI   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Frame state
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  ovf_r, ovf_nxt;

  // Configuration
  logic [LOW_FRAC_W-1:0] lf_r;
  logic [FRAC_W-1:0]     hf_r;

  // Sequencer datapath
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [D_W-1:0]        quo_r, quo_nxt;
  logic [IT_W-1:0]       it_r, it_nxt;
  logic [FRAC_W-1:0]     frac_sh_r, frac_sh_nxt;
  logic [AVG_W-1:0]      avg_r, avg_nxt;
  logic [D_W-1:0]        lo_r, lo_nxt;
  logic [D_W-1:0]        hi_r, hi_nxt;
  logic [CNT_W-1:0]      j_r, j_nxt;
  logic                  gt_r, gt_nxt;
  logic [WORD_W-1:0]     word_r, word_nxt;

  // Result registers
  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]     out_word_r, out_word_nxt;
  logic [AVG_W-1:0]      out_avg_r, out_avg_nxt;
  logic [SLOT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // Shared unit
  op_t                   unit_op;
  logic [ACC_W-1:0]      unit_a, unit_b, unit_res;
  logic                  unit_borrow;

  // Width store
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  // Helpers
  logic                  accept, room, it_last, j_last;
  logic                  div_bit;
  logic [CNT_W:0]        rem_sh;
  logic [CNT_W-1:0]      c_w, cnt_inc, j_inc, cnt_new, rem_step;
  logic [SUM_W-1:0]      sum_new;
  logic [D_W-1:0]        quo_step;
  logic [WORD_W-1:0]     word_step;
  logic [ACC_W-1:0]      acc_sh;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign room    = (cnt_r < CNT_W'(MAX_SLOTS));
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign cnt_new = room ? cnt_inc : cnt_r;
  assign sum_new = unit_res[SUM_W-1:0];
  assign c_w     = cnt_r - CNT_W'(1);
  assign j_inc   = j_r + CNT_W'(1);
  assign j_last  = (j_r == c_w);
  assign it_last = (it_r == IT_W'(1));

  // Restoring division step: shift one dividend bit into the remainder, try c.
  assign div_bit   = acc_r[D_W-1];
  assign rem_sh    = {rem_r, div_bit};
  assign rem_step  = unit_borrow ? rem_sh[CNT_W-1:0] : unit_res[CNT_W-1:0];
  assign quo_step  = {quo_r[D_W-2:0], !unit_borrow};
  assign acc_sh    = {acc_r[ACC_W-2:0], 1'b0};

  // In the high-side compare the borrow means high_count < hi; gt_r holds lo < high_count.
  assign word_step = {word_r[WORD_W-2:0], gt_r & unit_borrow};

  assign ram_we    = accept && room;
  assign ram_re    = (state_r == ST_CL_READ) || ((state_r == ST_CL_HI) && !j_last);
  assign ram_raddr = (state_r == ST_CL_HI) ? j_inc[ADDR_W-1:0] : j_r[ADDR_W-1:0];

  pdbfd_addsub #(
    .W (ACC_W)
  ) u_unit (
    .op     (unit_op),
    .a      (unit_a),
    .b      (unit_b),
    .res    (unit_res),
    .borrow (unit_borrow)
  );

  pdbfd_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_high_count),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    it_nxt        = it_r;
    frac_sh_nxt   = frac_sh_r;
    avg_nxt       = avg_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    gt_nxt        = gt_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    out_avg_nxt   = out_avg_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;
    unit_op       = OP_ADD;
    unit_a        = '0;
    unit_b        = '0;

    unique case (state_r)
      ST_IDLE: begin
        // Accumulate the period of every kept slot after the first.
        unit_op = OP_ADD;
        unit_a  = ACC_W'(sum_r);
        unit_b  = ((cnt_r != '0) && room) ? ACC_W'(in_period_count) : '0;
        if (accept) begin
          cnt_nxt = cnt_new;
          sum_nxt = sum_new;
          ovf_nxt = ovf_r | !room;
          if (in_last_slot) begin
            if (cnt_new > CNT_W'(1)) begin
              state_nxt = ST_AVG_DIV;
              acc_nxt   = ACC_W'(sum_new);
              rem_nxt   = '0;
              it_nxt    = IT_W'(D_W);
            end else begin
              // One-slot frame: no division, the word and the average read zero.
              out_valid_nxt = 1'b1;
              out_word_nxt  = '0;
              out_avg_nxt   = '0;
              out_cnt_nxt   = SLOT_CNT_W'(cnt_new);
              out_ovf_nxt   = ovf_r | !room;
              cnt_nxt       = '0;
              sum_nxt       = '0;
              ovf_nxt       = 1'b0;
            end
          end
        end
      end

      ST_AVG_DIV, ST_LO_DIV, ST_HI_DIV: begin
        unit_op = OP_SUB;
        unit_a  = ACC_W'(rem_sh);
        unit_b  = ACC_W'(c_w);
        acc_nxt = acc_sh;
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        it_nxt  = it_r - IT_W'(1);
        if (it_last) begin
          if (state_r == ST_AVG_DIV) begin
            avg_nxt     = AVG_W'(quo_step);
            state_nxt   = ST_LO_MUL;
            acc_nxt     = '0;
            it_nxt      = IT_W'(FRAC_W);
            frac_sh_nxt = FRAC_W'(lf_r);
          end else if (state_r == ST_LO_DIV) begin
            lo_nxt      = quo_step;
            state_nxt   = ST_HI_MUL;
            acc_nxt     = '0;
            it_nxt      = IT_W'(FRAC_W);
            frac_sh_nxt = hf_r;
          end else begin
            hi_nxt    = quo_step;
            state_nxt = ST_CL_READ;
            j_nxt     = '0;
            word_nxt  = '0;
          end
        end
      end

      ST_LO_MUL, ST_HI_MUL: begin
        // MSB-first shift-and-add of sum times fraction.
        unit_op     = OP_ADD;
        unit_a      = acc_sh;
        unit_b      = frac_sh_r[FRAC_W-1] ? ACC_W'(sum_r) : '0;
        acc_nxt     = unit_res;
        frac_sh_nxt = {frac_sh_r[FRAC_W-2:0], 1'b0};
        it_nxt      = it_r - IT_W'(1);
        if (it_last) begin
          // Drop the fraction bits, then divide by c.
          acc_nxt   = unit_res >> FRAC_SHIFT;
          rem_nxt   = '0;
          it_nxt    = IT_W'(D_W);
          state_nxt = (state_r == ST_LO_MUL) ? ST_LO_DIV : ST_HI_DIV;
        end
      end

      ST_CL_READ: begin
        state_nxt = ST_CL_LO;
      end

      ST_CL_LO: begin
        unit_op   = OP_SUB;
        unit_a    = ACC_W'(lo_r);
        unit_b    = ACC_W'(ram_rdata);
        gt_nxt    = unit_borrow;
        state_nxt = ST_CL_HI;
      end

      ST_CL_HI: begin
        unit_op  = OP_SUB;
        unit_a   = ACC_W'(ram_rdata);
        unit_b   = ACC_W'(hi_r);
        word_nxt = word_step;
        if (j_last) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = word_step;
          out_avg_nxt   = avg_r;
          out_cnt_nxt   = SLOT_CNT_W'(cnt_r);
          out_ovf_nxt   = ovf_r;
          cnt_nxt       = '0;
          sum_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          j_nxt     = j_inc;
          state_nxt = ST_CL_LO;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      lf_r        <= LOW_FRAC_RESET;
      hf_r        <= HIGH_FRAC_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOW_FRAC:  lf_r <= cfg_data[LOW_FRAC_W-1:0];
          REG_HIGH_FRAC: hf_r <= cfg_data[FRAC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    it_r       <= it_nxt;
    frac_sh_r  <= frac_sh_nxt;
    avg_r      <= avg_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    j_r        <= j_nxt;
    gt_r       <= gt_nxt;
    word_r     <= word_nxt;
    out_word_r <= out_word_nxt;
    out_avg_r  <= out_avg_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_response_word  = out_word_r;
  assign out_average_period = out_avg_r;
  assign out_slot_count     = out_cnt_r;
  assign out_overflow       = out_ovf_r;

  // A result word always reports at least one kept slot and never more than the store.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid |-> ((out_slot_count != '0) &&
                                  (out_slot_count <= SLOT_CNT_W'(MAX_SLOTS))))
    else $error("result word with impossible slot count");

  // Results appear only once the sequencer has returned to idle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  // A slot word without the last mark never starts a decode.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (start && !busy && !in_last_slot) |=> (!busy && !out_valid))
    else $error("non-final slot started a decode");

  // Dropped slots only happen with a full store.
  assert property (@(posedge clk) disable iff (!rst_n)
                   ovf_r |-> (cnt_r == CNT_W'(MAX_SLOTS)))
    else $error("overflow flagged with store not full");

endmodule

`default_nettype wire
